>>> design/gpmq_pkg.sv
`timescale 1ns / 1ps
package gpmq_pkg;

	localparam int FIELD_W     = 7;
	localparam int CFG_W       = 7;
	localparam int CFG_IDX_W   = 1;
	localparam int CELL_W      = 31;
	localparam logic [CELL_W-1:0] CELL_MAX = {CELL_W{1'b1}};

	localparam int MAX_ROWS_DEF    = 64;
	localparam int MAX_COLS_DEF    = 64;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int SIZE_RESET      = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

	typedef struct packed {
		logic clr_rst;
		logic clr_wr;
		logic ld;
		logic u_rd;
		logic u_wr;
		logic r_take;
		logic r_shift;
		logic c_take;
		logic c_shift;
		logic acc;
		logic out;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic in_query;
		logic in_upd_ok;
		logic i_one;
		logic j_one;
		logic row_done;
		logic row_take;
		logic col_done;
		logic col_take;
	} sts_t;

endpackage

>>> design/gpmq_ctrl.sv
`timescale 1ns / 1ps
module gpmq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              cfg_we,
	input  gpmq_pkg::sts_t    sts,
	output gpmq_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              done
);

	typedef enum logic [2:0] {
		S_IDLE, S_CLR, S_URD, S_UWR, S_QROW, S_QCOL, S_QACC, S_OUT
	} state_t;

	state_t state_q;
	logic   done_q;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	always_comb begin
		cmd = '0;
		cmd.clr_rst = cfg_we;
		case (state_q)
			S_IDLE: begin
				if (!cfg_we && start)
					cmd.ld = 1'b1;
			end
			S_CLR: begin
				if (!cfg_we)
					cmd.clr_wr = 1'b1;
			end
			S_URD: cmd.u_rd = 1'b1;
			S_UWR: cmd.u_wr = 1'b1;
			S_QROW: begin
				if (!sts.row_done) begin
					if (sts.row_take)
						cmd.r_take = 1'b1;
					else
						cmd.r_shift = 1'b1;
				end
			end
			S_QCOL: begin
				if (!sts.col_done) begin
					if (sts.col_take)
						cmd.c_take = 1'b1;
					else
						cmd.c_shift = 1'b1;
				end
			end
			S_QACC: cmd.acc = 1'b1;
			S_OUT:  cmd.out = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				state_q <= S_CLR;
			end else begin
				case (state_q)
					S_IDLE: begin
						if (start) begin
							if (sts.in_query)
								state_q <= S_QROW;
							else if (sts.in_upd_ok)
								state_q <= S_URD;
						end
					end
					S_CLR: begin
						if (sts.clr_last)
							state_q <= S_IDLE;
					end
					S_URD: state_q <= S_UWR;
					S_UWR: begin
						if (sts.i_one && sts.j_one)
							state_q <= S_IDLE;
						else
							state_q <= S_URD;
					end
					S_QROW: begin
						if (sts.row_done)
							state_q <= S_OUT;
						else if (sts.row_take)
							state_q <= S_QCOL;
					end
					S_QCOL: begin
						if (sts.col_done)
							state_q <= S_QROW;
						else if (sts.col_take)
							state_q <= S_QACC;
					end
					S_QACC: state_q <= S_QCOL;
					S_OUT: begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

endmodule

>>> design/gpmq_dp.sv
`timescale 1ns / 1ps
module gpmq_dp #(
	parameter int MAX_ROWS    = gpmq_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS    = gpmq_pkg::MAX_COLS_DEF,
	parameter int VALUE_WIDTH = gpmq_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gpmq_pkg::cmd_t                      cmd,
	output gpmq_pkg::sts_t                      sts,
	input  logic                                cfg_we,
	input  logic [gpmq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gpmq_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                mode,
	input  logic [gpmq_pkg::FIELD_W-1:0]        row_a,
	input  logic [gpmq_pkg::FIELD_W-1:0]        col_a,
	input  logic [gpmq_pkg::FIELD_W-1:0]        row_b,
	input  logic [gpmq_pkg::FIELD_W-1:0]        col_b,
	input  logic signed [VALUE_WIDTH-1:0]       value,
	output logic [gpmq_pkg::CELL_W-1:0]         max_value
);

	// bottom-up trees: node 1 is the root, leaves at P + index - 1
	localparam int LPR = $clog2(MAX_ROWS);
	localparam int LPC = $clog2(MAX_COLS);
	localparam int PR  = 2 ** LPR;
	localparam int PC  = 2 ** LPC;
	localparam int NWR = LPR + 2;
	localparam int NWC = LPC + 2;
	localparam int AW  = LPR + LPC + 2;
	localparam int FW  = gpmq_pkg::FIELD_W;
	localparam int CW  = gpmq_pkg::CELL_W;

	logic [CW-1:0] mem [0:(2**AW)-1];

	logic [FW-1:0]  rows_q, cols_q;
	logic [AW-1:0]  cnt_q;
	logic [CW-1:0]  rd_q, val_q, acc_q, max_value_q;
	logic [LPR:0]   i_q, rn_q;
	logic [LPC:0]   j_q, cleaf_q;
	logic [NWR-1:0] rl_q, rr_q;
	logic [NWC-1:0] cl_q, cr_q, c0_q, c1_q;

	logic [FW-1:0]  r0, r1, c0, c1;
	logic           row_empty, col_empty;
	logic [31:0]    rlf0, rlf1, clf0, clf1;
	logic [VALUE_WIDTH+31:0] vx;
	logic           sat;
	logic [CW-1:0]  val_in, upd_max;
	logic [AW-1:0]  wr_addr, rd_addr;
	logic [LPC:0]   csel;

	function automatic logic SIZE_OK(input int m);
		return gpmq_pkg::SIZE_RESET <= m;
	endfunction

	assign r0 = (row_a == '0) ? FW'(1) : row_a;
	assign c0 = (col_a == '0) ? FW'(1) : col_a;
	assign r1 = (row_b > rows_q) ? rows_q : row_b;
	assign c1 = (col_b > cols_q) ? cols_q : col_b;
	assign row_empty = (r0 > r1);
	assign col_empty = (c0 > c1);
	assign rlf0 = 32'(PR) + 32'(r0) - 32'd1;
	assign rlf1 = 32'(PR) + 32'(r1) - 32'd1;
	assign clf0 = 32'(PC) + 32'(c0) - 32'd1;
	assign clf1 = 32'(PC) + 32'(c1) - 32'd1;

	assign vx     = {32'd0, value};
	assign sat    = |vx[VALUE_WIDTH+30:31];
	assign val_in = sat ? gpmq_pkg::CELL_MAX : vx[30:0];

	assign upd_max = (rd_q > val_q) ? rd_q : val_q;
	assign csel    = cl_q[0] ? cl_q[LPC:0] : cr_q[LPC:0];
	assign wr_addr = cmd.clr_wr ? cnt_q : {i_q, j_q};
	assign rd_addr = cmd.c_take ? {rn_q, csel} : {i_q, j_q};

	always_comb begin
		sts.clr_last  = &cnt_q;
		sts.in_query  = mode;
		sts.in_upd_ok = (row_a != '0) && (row_a <= rows_q) && (col_a != '0) &&
			(col_a <= cols_q) && !value[VALUE_WIDTH-1];
		sts.i_one     = (i_q == (LPR+1)'(1));
		sts.j_one     = (j_q == (LPC+1)'(1));
		sts.row_done  = (rl_q > rr_q);
		sts.row_take  = rl_q[0] | ~rr_q[0];
		sts.col_done  = (cl_q > cr_q);
		sts.col_take  = cl_q[0] | ~cr_q[0];
	end

	assign max_value = max_value_q;

	always_ff @(posedge clk) begin
		if (cmd.clr_wr)
			mem[wr_addr] <= '0;
		else if (cmd.u_wr)
			mem[wr_addr] <= upd_max;
	end

	always_ff @(posedge clk) begin
		if (cmd.u_rd || cmd.c_take)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= (SIZE_OK(MAX_ROWS)) ? FW'(gpmq_pkg::SIZE_RESET) : FW'(MAX_ROWS);
			cols_q <= (SIZE_OK(MAX_COLS)) ? FW'(gpmq_pkg::SIZE_RESET) : FW'(MAX_COLS);
			cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == gpmq_pkg::CFG_ROWS)
					rows_q <= (cfg_data == '0) ? FW'(1) :
						((32'(cfg_data) > MAX_ROWS) ? FW'(MAX_ROWS) : cfg_data);
				else if (cfg_index == gpmq_pkg::CFG_COLS)
					cols_q <= (cfg_data == '0) ? FW'(1) :
						((32'(cfg_data) > MAX_COLS) ? FW'(MAX_COLS) : cfg_data);
			end
			if (cmd.clr_rst)
				cnt_q <= '0;
			else if (cmd.clr_wr)
				cnt_q <= cnt_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			acc_q   <= '0;
			val_q   <= val_in;
			i_q     <= rlf0[LPR:0];
			j_q     <= clf0[LPC:0];
			cleaf_q <= clf0[LPC:0];
			if (row_empty) begin
				rl_q <= NWR'(1);
				rr_q <= '0;
			end else begin
				rl_q <= rlf0[NWR-1:0];
				rr_q <= rlf1[NWR-1:0];
			end
			if (col_empty) begin
				c0_q <= NWC'(1);
				c1_q <= '0;
			end else begin
				c0_q <= clf0[NWC-1:0];
				c1_q <= clf1[NWC-1:0];
			end
		end
		if (cmd.u_wr) begin
			if (j_q == (LPC+1)'(1)) begin
				j_q <= cleaf_q;
				i_q <= i_q >> 1;
			end else begin
				j_q <= j_q >> 1;
			end
		end
		if (cmd.r_take) begin
			cl_q <= c0_q;
			cr_q <= c1_q;
			if (rl_q[0]) begin
				rn_q <= rl_q[LPR:0];
				rl_q <= rl_q + NWR'(1);
			end else begin
				rn_q <= rr_q[LPR:0];
				rr_q <= rr_q - NWR'(1);
			end
		end
		if (cmd.r_shift) begin
			rl_q <= rl_q >> 1;
			rr_q <= rr_q >> 1;
		end
		if (cmd.c_take) begin
			if (cl_q[0])
				cl_q <= cl_q + NWC'(1);
			else
				cr_q <= cr_q - NWC'(1);
		end
		if (cmd.c_shift) begin
			cl_q <= cl_q >> 1;
			cr_q <= cr_q >> 1;
		end
		if (cmd.acc && (rd_q > acc_q))
			acc_q <= rd_q;
		if (cmd.out)
			max_value_q <= acc_q;
	end

endmodule

>>> design/grid_point_max_rect_query.sv
`timescale 1ns / 1ps
// Update: one read and one write per node, for each pair of row and column tree nodes on the leaf-to-root paths.
// Query: each row node covering the range is taken, then each covering column node under it
// is read and folded into the maximum; done rises once every row node has been taken.
// Result word: done pulses for one cycle with max_value; the receiver cannot stall.
// Reset and any register write start a clearing pass over all (2R)*(2C) words, busy high.
// R, C: MAX_ROWS, MAX_COLS rounded up to powers of two.
module grid_point_max_rect_query #(
	parameter int MAX_ROWS    = gpmq_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS    = gpmq_pkg::MAX_COLS_DEF,
	parameter int VALUE_WIDTH = gpmq_pkg::VALUE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            mode,
	input  logic [gpmq_pkg::FIELD_W-1:0]    row_a,
	input  logic [gpmq_pkg::FIELD_W-1:0]    col_a,
	input  logic [gpmq_pkg::FIELD_W-1:0]    row_b,
	input  logic [gpmq_pkg::FIELD_W-1:0]    col_b,
	input  logic signed [VALUE_WIDTH-1:0]   value,
	output logic                            done,
	output logic [gpmq_pkg::CELL_W-1:0]     max_value,
	input  logic                            cfg_we,
	input  logic [gpmq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gpmq_pkg::CFG_W-1:0]      cfg_data
);

	gpmq_pkg::cmd_t cmd;
	gpmq_pkg::sts_t sts;

	gpmq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cfg_we (cfg_we),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	gpmq_dp #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLS    (MAX_COLS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mode      (mode),
		.row_a     (row_a),
		.col_a     (col_a),
		.row_b     (row_b),
		.col_b     (col_b),
		.value     (value),
		.max_value (max_value)
	);

endmodule
